// File: rtl/tpilm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpilm_pkg;

    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned LIMIT_W = 23;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned INTEG_W = 24;
    localparam int unsigned STEPS_W = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_PITCH_KP = 3'd0;
    localparam logic [2:0] REG_PITCH_KI = 3'd1;
    localparam logic [2:0] REG_ROLL_KP  = 3'd2;
    localparam logic [2:0] REG_ROLL_KI  = 3'd3;
    localparam logic [2:0] REG_LIMIT    = 3'd4;
    localparam logic [2:0] REG_SCALE    = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 16'd256;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN = 16'd0;
    localparam logic [LIMIT_W-1:0] RST_LIMIT      = 23'd25600;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 16'd15360;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic AXIS_PITCH = 1'b0;
    localparam logic AXIS_ROLL  = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] pitch_kp;
        logic signed [GAIN_W-1:0] pitch_ki;
        logic signed [GAIN_W-1:0] roll_kp;
        logic signed [GAIN_W-1:0] roll_ki;
        logic [LIMIT_W-1:0]       limit;
        logic [SCALE_W-1:0]       scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic clear;
        logic integ;
        logic mul_kp;
        logic mul_ki;
        logic mul_slo;
        logic mul_shi;
        logic mix;
        logic axis;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/tpilm_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tpilm_regs import tpilm_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_kp <= RST_PROP_GAIN;
            r_cfg.pitch_ki <= RST_INTEG_GAIN;
            r_cfg.roll_kp  <= RST_PROP_GAIN;
            r_cfg.roll_ki  <= RST_INTEG_GAIN;
            r_cfg.limit    <= RST_LIMIT;
            r_cfg.scale    <= RST_SCALE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PITCH_KP: r_cfg.pitch_kp <= pwdata[GAIN_W-1:0];
                REG_PITCH_KI: r_cfg.pitch_ki <= pwdata[GAIN_W-1:0];
                REG_ROLL_KP:  r_cfg.roll_kp  <= pwdata[GAIN_W-1:0];
                REG_ROLL_KI:  r_cfg.roll_ki  <= pwdata[GAIN_W-1:0];
                REG_LIMIT:    r_cfg.limit    <= pwdata[LIMIT_W-1:0];
                REG_SCALE:    r_cfg.scale    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PITCH_KP: prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.pitch_kp};
            REG_PITCH_KI: prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.pitch_ki};
            REG_ROLL_KP:  prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.roll_kp};
            REG_ROLL_KI:  prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.roll_ki};
            REG_LIMIT:    prdata = {{(DATA_W-LIMIT_W){1'b0}}, r_cfg.limit};
            REG_SCALE:    prdata = {{(DATA_W-SCALE_W){1'b0}}, r_cfg.scale};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tpilm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tpilm_ctrl import tpilm_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    input  wire      i_command,
    output logic     o_stall,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INTEG = 8'b0000_0010,
        S_KP    = 8'b0000_0100,
        S_KI    = 8'b0000_1000,
        S_SLO   = 8'b0001_0000,
        S_SHI   = 8'b0010_0000,
        S_MIX   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid & (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AXIS_PITCH;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_INTEG;
                    end
                end
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_axis      = AXIS_PITCH;
                n_state     = S_KP;
            end
            S_KP: begin
                o_cmd.mul_kp = 1'b1;
                n_state      = S_KI;
            end
            S_KI: begin
                o_cmd.mul_ki = 1'b1;
                n_state      = S_SLO;
            end
            S_SLO: begin
                o_cmd.mul_slo = 1'b1;
                n_state       = S_SHI;
            end
            S_SHI: begin
                o_cmd.mul_shi = 1'b1;
                n_state       = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                if (r_axis == AXIS_PITCH) begin
                    n_axis  = AXIS_ROLL;
                    n_state = S_KP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold here until the result register has room.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tpilm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tpilm_dp import tpilm_pkg::*; (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  wire  signed [ANGLE_W-1:0]   i_pitch_angle,
    input  wire  signed [ANGLE_W-1:0]   i_roll_angle,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [STEPS_W-1:0]   o_motor_one_steps,
    output logic signed [STEPS_W-1:0]   o_motor_two_steps
);

    localparam int unsigned SUM_W  = INTEG_W + 1;   // integral plus error
    localparam int unsigned MA_W   = 25;            // multiplier operand A
    localparam int unsigned MB_W   = 17;            // multiplier operand B
    localparam int unsigned PROD_W = MA_W + MB_W;
    localparam int unsigned ACC_W  = 41;            // kp*e + ki*i
    localparam int unsigned SPLIT  = 24;
    localparam int unsigned SCL_W  = 58;            // axis * scale
    localparam int unsigned MIX_W  = 60;
    localparam int unsigned TR_W   = MIX_W - SPLIT;

    // Divide by 2^24 towards zero, then saturate to 32 bits.
    function automatic logic signed [STEPS_W-1:0] trunc_sat(input logic signed [MIX_W-1:0] x);
        logic signed [MIX_W-1:0] adj;
        logic signed [TR_W-1:0]  t;
        adj = x;
        if (x[MIX_W-1]) begin
            adj = x + MIX_W'((64'd1 << SPLIT) - 64'd1);
        end
        t = adj[MIX_W-1:SPLIT];
        if (t[TR_W-1] == 1'b0 && t[TR_W-2:STEPS_W-1] != '0) begin
            trunc_sat = {1'b0, {(STEPS_W-1){1'b1}}};
        end else if (t[TR_W-1] == 1'b1 && t[TR_W-2:STEPS_W-1] != '1) begin
            trunc_sat = {1'b1, {(STEPS_W-1){1'b0}}};
        end else begin
            trunc_sat = t[STEPS_W-1:0];
        end
    endfunction

    logic signed [ANGLE_W-1:0] r_err_p, r_err_r;
    logic signed [INTEG_W-1:0] r_int_p, r_int_r;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SCL_W-1:0]   r_scl;
    logic signed [SCL_W-1:0]   r_p;
    logic signed [MIX_W-1:0]   r_diff, r_nsum;
    logic                      r_out_valid;

    logic signed [SUM_W-1:0]   lim_pos, lim_neg;
    logic signed [SUM_W-1:0]   sum_p, sum_r;
    logic signed [INTEG_W-1:0] clamp_p, clamp_r;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ANGLE_W-1:0] err_sel;
    logic signed [INTEG_W-1:0] int_sel;
    logic signed [GAIN_W-1:0]  kp_sel, ki_sel;
    logic signed [MIX_W-1:0]   p_ext, s_ext;

    assign lim_pos = {2'b00, i_cfg.limit};
    assign lim_neg = -lim_pos;
    assign sum_p   = SUM_W'(r_int_p) + SUM_W'(r_err_p);
    assign sum_r   = SUM_W'(r_int_r) + SUM_W'(r_err_r);

    always_comb begin
        if (sum_p > lim_pos)      clamp_p = lim_pos[INTEG_W-1:0];
        else if (sum_p < lim_neg) clamp_p = lim_neg[INTEG_W-1:0];
        else                      clamp_p = sum_p[INTEG_W-1:0];
        if (sum_r > lim_pos)      clamp_r = lim_pos[INTEG_W-1:0];
        else if (sum_r < lim_neg) clamp_r = lim_neg[INTEG_W-1:0];
        else                      clamp_r = sum_r[INTEG_W-1:0];
    end

    assign err_sel = (i_cmd.axis == AXIS_ROLL) ? r_err_r : r_err_p;
    assign int_sel = (i_cmd.axis == AXIS_ROLL) ? r_int_r : r_int_p;
    assign kp_sel  = (i_cmd.axis == AXIS_ROLL) ? i_cfg.roll_kp : i_cfg.pitch_kp;
    assign ki_sel  = (i_cmd.axis == AXIS_ROLL) ? i_cfg.roll_ki : i_cfg.pitch_ki;

    // One shared multiplier; the scale product is split into a low unsigned
    // part and a high signed part of the accumulated axis value.
    always_comb begin
        mul_a = MA_W'(err_sel);
        mul_b = MB_W'(kp_sel);
        if (i_cmd.mul_ki) begin
            mul_a = MA_W'(int_sel);
            mul_b = MB_W'(ki_sel);
        end else if (i_cmd.mul_slo) begin
            mul_a = {1'b0, r_acc[SPLIT-1:0]};
            mul_b = {1'b0, i_cfg.scale};
        end else if (i_cmd.mul_shi) begin
            mul_a = MA_W'($signed(r_acc[ACC_W-1:SPLIT]));
            mul_b = {1'b0, i_cfg.scale};
        end
    end

    assign prod  = mul_a * mul_b;
    assign p_ext = MIX_W'(r_p);
    assign s_ext = MIX_W'(r_scl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_p <= '0;
            r_int_r <= '0;
        end else if (i_cmd.clear) begin
            r_int_p <= '0;
            r_int_r <= '0;
        end else if (i_cmd.integ) begin
            r_int_p <= clamp_p;
            r_int_r <= clamp_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err_p <= i_pitch_angle;
            r_err_r <= i_roll_angle;
        end
        if (i_cmd.mul_kp) begin
            r_acc <= prod[ACC_W-1:0];
        end
        if (i_cmd.mul_ki) begin
            r_acc <= r_acc + prod[ACC_W-1:0];
        end
        if (i_cmd.mul_slo) begin
            r_scl <= SCL_W'(prod);
        end
        if (i_cmd.mul_shi) begin
            r_scl <= r_scl + {prod[SCL_W-SPLIT-1:0], {SPLIT{1'b0}}};
        end
        if (i_cmd.mix) begin
            if (i_cmd.axis == AXIS_PITCH) begin
                r_p <= r_scl;
            end else begin
                r_diff <= p_ext - s_ext;
                r_nsum <= -p_ext - s_ext;
            end
        end
        if (i_cmd.out_load) begin
            o_motor_one_steps <= trunc_sat(r_diff);
            o_motor_two_steps <= trunc_sat(r_nsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sts.out_free = !r_out_valid || !i_stall;

endmodule

`default_nettype wire

// File: rtl/two_axis_pi_leveling_mixer_top.sv
// An update item runs the integrate state, then per axis the kp, ki, scale-low,
// scale-high and mix states, one multiply of the shared 25x17 multiplier per
// cycle, four per axis, and the output state, which waits for a free result
// register; a new item is taken only back in idle. A clear item gives no result.
// Reset (synchronous, active low) zeroes both integrals, loads the default
// gains, limit and scale, and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module two_axis_pi_leveling_mixer_top import tpilm_pkg::*; (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_command,
    input  wire  signed [ANGLE_W-1:0]   i_pitch_angle,
    input  wire  signed [ANGLE_W-1:0]   i_roll_angle,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [STEPS_W-1:0]   o_motor_one_steps,
    output logic signed [STEPS_W-1:0]   o_motor_two_steps,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [ADDR_W-1:0]           paddr,
    input  wire  [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    tpilm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tpilm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    tpilm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_pitch_angle     (i_pitch_angle),
        .i_roll_angle      (i_roll_angle),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_motor_one_steps (o_motor_one_steps),
        .o_motor_two_steps (o_motor_two_steps)
    );

endmodule

`default_nettype wire

// File: verif/two_axis_pi_leveling_mixer_top_tb.sv
`timescale 1ns / 1ps

module two_axis_pi_leveling_mixer_top_tb;

    import tpilm_pkg::*;

    localparam int     CYCLE_LIMIT   = 300000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     NUM_PHASES    = 8;
    localparam int     DIRECTED_ROWS = 25;
    localparam longint STEP_UNIT     = 64'sd16777216;
    localparam longint STEPS_HI      = 64'sd2147483647;
    localparam longint STEPS_LO      = -64'sd2147483648;

    // Register slots that decode to nothing.
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_WRITE} t_row_kind;

    typedef enum logic [1:0] {
        CFG_RANDOM, CFG_ZERO_LIMIT, CFG_WINDUP_SUM, CFG_WINDUP_DIFF
    } t_phase_style;

    typedef struct packed {
        logic signed [STEPS_W-1:0] one;
        logic signed [STEPS_W-1:0] two;
    } t_motor_pair;

    typedef struct {
        t_row_kind                 kind;
        logic                      cmd;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [STEPS_W-1:0] want_one;
        logic signed [STEPS_W-1:0] want_two;
        logic [2:0]                reg_idx;
        logic [DATA_W-1:0]         reg_val;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      i_command     = CMD_UPDATE;
    logic signed [ANGLE_W-1:0] i_pitch_angle = '0;
    logic signed [ANGLE_W-1:0] i_roll_angle  = '0;
    logic                      i_stall       = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [ADDR_W-1:0]         paddr         = '0;
    logic [DATA_W-1:0]         pwdata        = '0;
    wire                       o_stall;
    wire                       o_valid;
    wire signed [STEPS_W-1:0]  o_motor_one_steps;
    wire signed [STEPS_W-1:0]  o_motor_two_steps;
    wire [DATA_W-1:0]          prdata;
    wire                       pready;

    two_axis_pi_leveling_mixer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_pitch_angle     (i_pitch_angle),
        .i_roll_angle      (i_roll_angle),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_motor_one_steps (o_motor_one_steps),
        .o_motor_two_steps (o_motor_two_steps),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Predictor state: configuration and the two integrals.
    t_cfg                      level_cfg;
    logic signed [INTEG_W-1:0] pitch_integ;
    logic signed [INTEG_W-1:0] roll_integ;
    t_motor_pair               pending_motor_steps [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int stall_hold     = 0;
    bit quiet_tail     = 1'b0;
    int pitch_sign     = 1;
    int roll_sign      = 1;

    // Angles in Q8.8: 256 is one degree. With the reset gains and scale one
    // degree of pitch gives 60 steps.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CHECKED, CMD_UPDATE, 16'sd0,      16'sd0,      32'sd0,      32'sd0,     '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, 16'sd256,    16'sd0,      32'sd60,     -32'sd60,   '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, 16'sd0,      16'sd256,    -32'sd60,    -32'sd60,   '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, 16'sd32767,  -16'sd32768, 32'sd15359,  32'sd0,     '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, -16'sd32768, 16'sd32767,  -32'sd15359, 32'sd0,     '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, -16'sd32768, -16'sd32768, 32'sd0,      32'sd15360, '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, 16'sd1,      -16'sd1,     32'sd0,      32'sd0,     '0, '0},
        '{ROW_CHECKED, CMD_UPDATE, -16'sd256,   -16'sd256,   32'sd0,      32'sd120,   '0, '0},
        '{ROW_ITEM,    CMD_CLEAR,  16'sd32767,  -16'sd32768, '0, '0, '0, '0},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_PITCH_KI, 32'h0000_0100},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_ROLL_KI,  32'hFFFF_FF00},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_LIMIT,    32'h0000_0200},
        '{ROW_ITEM,    CMD_UPDATE, 16'sd256,    16'sd256,    '0, '0, '0, '0},
        '{ROW_ITEM,    CMD_UPDATE, 16'sd256,    16'sd256,    '0, '0, '0, '0},
        '{ROW_ITEM,    CMD_UPDATE, 16'sd256,    16'sd256,    '0, '0, '0, '0},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_LIMIT,    32'hFF80_0000},
        '{ROW_ITEM,    CMD_UPDATE, 16'sd32767,  -16'sd32768, '0, '0, '0, '0},
        '{ROW_ITEM,    CMD_CLEAR,  16'sd0,      16'sd0,      '0, '0, '0, '0},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_PITCH_KP, 32'h0000_8000},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_ROLL_KP,  32'h0000_7FFF},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_SCALE,    32'hFFFF_0000},
        '{ROW_CHECKED, CMD_UPDATE, -16'sd32768, 16'sd32767,  32'sd0,      32'sd0,     '0, '0},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_SCALE,    32'h0000_FFFF},
        '{ROW_WRITE,   CMD_UPDATE, '0, '0, '0, '0, REG_UNUSED_LO, 32'hFFFF_FFFF},
        '{ROW_ITEM,    CMD_UPDATE, -16'sd32768, 16'sd32767,  '0, '0, '0, '0}
    };

    t_phase_style plan_style [NUM_PHASES] = '{
        CFG_RANDOM, CFG_WINDUP_SUM, CFG_ZERO_LIMIT, CFG_RANDOM,
        CFG_RANDOM, CFG_RANDOM, CFG_WINDUP_DIFF, CFG_RANDOM
    };
    int plan_items [NUM_PHASES] = '{120, 360, 100, 100, 100, 100, 360, 100};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Per axis: integral clamped, then kp*e + ki*i scaled by steps per degree (Q40.24).
    function automatic longint axis_scaled(
        input  logic signed [INTEG_W-1:0] integ_now,
        input  logic signed [ANGLE_W-1:0] err,
        input  logic signed [GAIN_W-1:0]  kp,
        input  logic signed [GAIN_W-1:0]  ki,
        output logic signed [INTEG_W-1:0] integ_next
    );
        longint lim;
        longint acc;
        lim = longint'({1'b0, level_cfg.limit});
        acc = longint'(integ_now) + longint'(err);
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ_next = acc[INTEG_W-1:0];
        return (longint'(kp) * longint'(err) + longint'(ki) * acc)
               * longint'({1'b0, level_cfg.scale});
    endfunction

    function automatic logic signed [STEPS_W-1:0] to_steps(input longint q);
        longint whole;
        whole = q / STEP_UNIT;
        if (whole > STEPS_HI) whole = STEPS_HI;
        if (whole < STEPS_LO) whole = STEPS_LO;
        return whole[STEPS_W-1:0];
    endfunction

    function automatic t_motor_pair level_update(input logic signed [ANGLE_W-1:0] pitch,
                                                 input logic signed [ANGLE_W-1:0] roll);
        longint                    p;
        longint                    r;
        logic signed [INTEG_W-1:0] next_pitch;
        logic signed [INTEG_W-1:0] next_roll;
        t_motor_pair               res;
        p = axis_scaled(pitch_integ, pitch, level_cfg.pitch_kp, level_cfg.pitch_ki, next_pitch);
        r = axis_scaled(roll_integ, roll, level_cfg.roll_kp, level_cfg.roll_ki, next_roll);
        pitch_integ = next_pitch;
        roll_integ  = next_roll;
        res.one = to_steps(p - r);
        res.two = to_steps(-(p + r));
        return res;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        case (idx)
            REG_PITCH_KP: level_cfg.pitch_kp = val[GAIN_W-1:0];
            REG_PITCH_KI: level_cfg.pitch_ki = val[GAIN_W-1:0];
            REG_ROLL_KP:  level_cfg.roll_kp  = val[GAIN_W-1:0];
            REG_ROLL_KI:  level_cfg.roll_ki  = val[GAIN_W-1:0];
            REG_LIMIT:    level_cfg.limit    = val[LIMIT_W-1:0];
            REG_SCALE:    level_cfg.scale    = val[SCALE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            3, 4: return 16'($urandom_range(0, 4095)) - 16'd2048;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] windup_angle(input int sign);
        int unsigned mag;
        mag = $urandom_range(30000, 32767);
        return (sign > 0) ? 16'(mag) : 16'(-mag);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 23'h7F_FFFF;
            2: return 23'($urandom_range(0, 4096));
            default: return 23'($urandom_range(0, 23'h7F_FFFF));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15000, 15700));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic log_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_motor_steps.size() != 0) @(posedge i_clk);
        // A clear item gives no result, so allow the pipeline to empty.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input logic cmd, input logic [ANGLE_W-1:0] pitch,
                             input logic [ANGLE_W-1:0] roll, input bit fixed_want,
                             input t_motor_pair want);
        t_motor_pair predicted;
        int          gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_pitch_angle <= pitch;
        i_roll_angle  <= roll;
        do @(posedge i_clk); while (o_stall);
        if (cmd == CMD_CLEAR) begin
            pitch_integ = '0;
            roll_integ  = '0;
        end else begin
            predicted = level_update(pitch, roll);
            pending_motor_steps.push_back(fixed_want ? want : predicted);
        end
    endtask

    task automatic configure_phase(input t_phase_style style);
        logic [GAIN_W-1:0] pitch_gain;
        logic [GAIN_W-1:0] roll_gain;
        int                push;
        int                roll_push;
        if (style == CFG_WINDUP_SUM || style == CFG_WINDUP_DIFF) begin
            // Extreme gains and a full limit, with angle signs chosen so that both
            // integrals wind up and the axis outputs add (or cancel) in one motor.
            pitch_gain = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            roll_gain  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            push       = $urandom_range(0, 1) ? 1 : -1;
            roll_push  = (style == CFG_WINDUP_SUM) ? push : -push;
            pitch_sign = pitch_gain[GAIN_W-1] ? -push : push;
            roll_sign  = roll_gain[GAIN_W-1] ? -roll_push : roll_push;
            reg_write(REG_LIMIT, {9'($urandom), 23'h7F_FFFF});
            reg_write(REG_SCALE, {16'($urandom), 16'hFFFF});
        end else begin
            pitch_gain = pick_gain();
            roll_gain  = pick_gain();
            reg_write(REG_LIMIT, {9'($urandom),
                                  (style == CFG_ZERO_LIMIT) ? 23'd0 : pick_limit()});
            reg_write(REG_SCALE, {16'($urandom), pick_scale()});
        end
        reg_write(REG_PITCH_KP, {16'($urandom), pitch_gain});
        reg_write(REG_ROLL_KP,  {16'($urandom), roll_gain});
        if (style == CFG_WINDUP_SUM || style == CFG_WINDUP_DIFF) begin
            reg_write(REG_PITCH_KI, {16'($urandom), pitch_gain});
            reg_write(REG_ROLL_KI,  {16'($urandom), roll_gain});
        end else begin
            reg_write(REG_PITCH_KI, {16'($urandom), pick_gain()});
            reg_write(REG_ROLL_KI,  {16'($urandom), pick_gain()});
            if ($urandom_range(0, 2) == 0) reg_write(REG_UNUSED_HI, $urandom);
        end
    endtask

    // Result side: random stall bursts between runs of free cycles.
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            i_stall    <= 1'b1;
            stall_hold = $urandom_range(0, 8);
        end else begin
            i_stall    <= 1'b0;
            stall_hold = $urandom_range(0, 19);
        end
    end

    always @(posedge i_clk) begin
        t_motor_pair want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_motor_steps.size() == 0) begin
                log_error($sformatf("result with none expected: motor one %0d, motor two %0d",
                                    o_motor_one_steps, o_motor_two_steps));
            end else begin
                want = pending_motor_steps.pop_front();
                if (o_motor_one_steps !== want.one)
                    log_error($sformatf("motor one steps: expected %0d, got %0d",
                                        want.one, o_motor_one_steps));
                if (o_motor_two_steps !== want.two)
                    log_error($sformatf("motor two steps: expected %0d, got %0d",
                                        want.two, o_motor_two_steps));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        t_stim_row row;
        bit        windup;
        logic      cmd;
        level_cfg.pitch_kp = RST_PROP_GAIN;
        level_cfg.pitch_ki = RST_INTEG_GAIN;
        level_cfg.roll_kp  = RST_PROP_GAIN;
        level_cfg.roll_ki  = RST_INTEG_GAIN;
        level_cfg.limit    = RST_LIMIT;
        level_cfg.scale    = RST_SCALE;
        pitch_integ        = '0;
        roll_integ         = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_WRITE: begin
                    drain_results();
                    reg_write(row.reg_idx, row.reg_val);
                end
                ROW_CHECKED: send_item(row.cmd, row.pitch, row.roll, 1'b1,
                                       '{row.want_one, row.want_two});
                default: send_item(row.cmd, row.pitch, row.roll, 1'b0, '0);
            endcase
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            configure_phase(plan_style[ph]);
            quiet_tail = (ph == NUM_PHASES - 1);
            windup = (plan_style[ph] == CFG_WINDUP_SUM || plan_style[ph] == CFG_WINDUP_DIFF);
            if (windup) send_item(CMD_CLEAR, pick_angle(), pick_angle(), 1'b0, '0);
            for (int n = 0; n < plan_items[ph]; n++) begin
                if (windup) begin
                    if ($urandom_range(0, 299) == 0)
                        send_item(CMD_CLEAR, pick_angle(), pick_angle(), 1'b0, '0);
                    else if ($urandom_range(0, 19) == 0)
                        send_item(CMD_UPDATE, pick_angle(), pick_angle(), 1'b0, '0);
                    else
                        send_item(CMD_UPDATE, windup_angle(pitch_sign),
                                  windup_angle(roll_sign), 1'b0, '0);
                end else begin
                    cmd = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_UPDATE;
                    send_item(cmd, pick_angle(), pick_angle(), 1'b0, '0);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_motor_steps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
